>>> hw/rtl/sparse_row_sorted_insert_top_macros.svh
// Assertion macros used by the sparse row insert top level.
`ifndef SPARSE_ROW_SORTED_INSERT_TOP_MACROS_SVH
`define SPARSE_ROW_SORTED_INSERT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SRSI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SRSI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SRSI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SRSI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/srsi_pkg.sv
// Package with widths, status codes and shared types of the sparse row insert block.
`default_nettype none
package srsi_pkg;
	localparam int ROW_COUNT_DEF = 1024;
	localparam int SLOTS_DEF     = 32;
	localparam int ROW_IDX_W     = 10;
	localparam int COL_W         = 10;
	localparam int ENTRY_W       = COL_W + 1;
	localparam int SLOT_W        = 5;
	localparam int FILL_W        = 6;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_PRESENT  = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef struct packed {
		logic                  insert;
		status_t               status;
		logic [SLOT_W-1:0]     slot;
		logic [FILL_W-1:0]     fill;
	} upd_res_t;
endpackage
`default_nettype wire

>>> hw/rtl/sparse_row_sorted_insert_top.sv
// Top level of the sparse row insert block: control, row store and result register.
// Usage: each input transfer names a row and a column; the column is placed in the
// row's ascending list of distinct columns, and one result transfer follows with the
// status, the slot and the row's fill after the update.
// Input channel: in_valid, in_ready, row_index, column_index.
// Output channel: out_valid, out_ready, status, slot_position, row_fill.
// The row word is read at the input transfer, its compare flags are registered in
// S_CMP, and in S_DEC the row is written back with the result loaded into the
// output register. No new input transfer is taken until that write-back is done,
// since in_ready is high only in S_IDLE.
// After reset the block clears the row store, one row per cycle, through all
// ROW_COUNT rows; in_ready stays low until that pass ends.
// The output register decouples the sides: a new input transfer is taken while a
// result still waits. If the receiver stalls with the register full, the finished
// update waits and no further input transfer is taken.
`default_nettype none
`include "sparse_row_sorted_insert_top_macros.svh"
module sparse_row_sorted_insert_top #(
	parameter int ROW_COUNT     = srsi_pkg::ROW_COUNT_DEF,
	parameter int SLOTS_PER_ROW = srsi_pkg::SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [srsi_pkg::ROW_IDX_W-1:0]  row_index,
	input  wire logic [srsi_pkg::COL_W-1:0]      column_index,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [1:0]                           status,
	output logic [srsi_pkg::SLOT_W-1:0]          slot_position,
	output logic [srsi_pkg::FILL_W-1:0]          row_fill
);
	localparam int ROW_AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int WIDTH  = SLOTS_PER_ROW * srsi_pkg::ENTRY_W;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_CMP   = 4'b0100,
		S_DEC   = 4'b1000
	} state_t;

	state_t                                        state_q;
	logic [ROW_AW-1:0]                             clr_q, row_q;
	logic [srsi_pkg::COL_W-1:0]                    col_q;
	logic                                          oor_q;
	logic                                          out_valid_q;
	srsi_pkg::status_t                             status_q;
	logic [srsi_pkg::SLOT_W-1:0]                   slot_q;
	logic [srsi_pkg::FILL_W-1:0]                   fill_q;
	logic                                          accept, adv, clearing, mem_we;
	logic [ROW_AW-1:0]                             waddr;
	logic [WIDTH-1:0]                              wdata;
	logic [SLOTS_PER_ROW-1:0][srsi_pkg::ENTRY_W-1:0] row_rd, row_wr;
	srsi_pkg::upd_res_t                            res;

	assign clearing = (state_q == S_CLEAR);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign adv      = (state_q == S_DEC) && (!out_valid_q || out_ready);
	assign mem_we   = clearing || (adv && !oor_q && res.insert);
	assign waddr    = clearing ? clr_q : row_q;
	assign wdata    = clearing ? '0 : row_wr;

	srsi_row_mem #(
		.ROW_COUNT(ROW_COUNT),
		.WIDTH(WIDTH)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(waddr),
		.wdata(wdata),
		.re(accept),
		.raddr(ROW_AW'(row_index)),
		.rdata(row_rd)
	);

	srsi_row_logic #(
		.SLOTS(SLOTS_PER_ROW)
	) u_logic (
		.clk(clk),
		.cap_en(state_q == S_CMP),
		.row_rd(row_rd),
		.col(col_q),
		.row_wr(row_wr),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ROW_AW'(1);
					if (clr_q == ROW_AW'(ROW_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (adv) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= ROW_AW'(row_index);
			col_q <= column_index;
			oor_q <= (32'(row_index) >= ROW_COUNT);
		end
		if (adv) begin
			if (oor_q) begin
				status_q <= srsi_pkg::ST_FULL;
				slot_q   <= '0;
				fill_q   <= '0;
			end else begin
				status_q <= res.status;
				slot_q   <= res.slot;
				fill_q   <= res.fill;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot_position = slot_q;
	assign row_fill      = fill_q;

	`SRSI_ASSERT_IMP(a_no_write_on_accept, clk, arst_n, mem_we, !accept)
	`SRSI_ASSERT_NXT(a_result_loaded, clk, arst_n, adv, out_valid && (state_q == S_IDLE))
	`SRSI_ASSERT_IMP(a_full_slot_zero, clk, arst_n, out_valid && (status == srsi_pkg::ST_FULL), slot_position == '0)
	`SRSI_ASSERT_IMP(a_insert_fill, clk, arst_n, out_valid && (status == srsi_pkg::ST_INSERTED), row_fill != '0)
endmodule
`default_nettype wire

>>> hw/rtl/srsi_row_mem.sv
// Row store: one wide word per row, one write and one registered read port.
`default_nettype none
module srsi_row_mem #(
	parameter int ROW_COUNT = srsi_pkg::ROW_COUNT_DEF,
	parameter int WIDTH     = srsi_pkg::SLOTS_DEF * srsi_pkg::ENTRY_W,
	localparam int AW       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [ROW_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/srsi_row_logic.sv
// Row compare stage and insertion datapath: slot flags, position encode and shift.
`default_nettype none
module srsi_row_logic #(
	parameter int SLOTS = srsi_pkg::SLOTS_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          cap_en,
	input  wire logic [SLOTS-1:0][srsi_pkg::ENTRY_W-1:0]       row_rd,
	input  wire logic [srsi_pkg::COL_W-1:0]                    col,
	output logic      [SLOTS-1:0][srsi_pkg::ENTRY_W-1:0]       row_wr,
	output srsi_pkg::upd_res_t                                 res
);
	localparam int SW = $clog2(SLOTS);
	localparam int FW = $clog2(SLOTS + 1);

	logic [SLOTS-1:0] vld_c, ge_c, eq_c;
	logic [SLOTS-1:0] vld_s2, ge_s2, eq_s2;
	logic [SLOTS-1:0] stop_oh, hole_oh;
	logic [SW-1:0]    pos;
	logic [FW-1:0]    fill_enc, fill, fill_inc;
	logic             all_valid, eq_hit, any_ge;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			vld_c[i] = row_rd[i][srsi_pkg::ENTRY_W-1];
			eq_c[i]  = vld_c[i] && (row_rd[i][srsi_pkg::COL_W-1:0] == col);
			ge_c[i]  = !vld_c[i] || (col <= row_rd[i][srsi_pkg::COL_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cap_en) begin
			vld_s2 <= vld_c;
			ge_s2  <= ge_c;
			eq_s2  <= eq_c;
		end
	end

	assign stop_oh   = ge_s2 & ~{ge_s2[SLOTS-2:0], 1'b0};
	assign hole_oh   = ~vld_s2 & {vld_s2[SLOTS-2:0], 1'b1};
	assign all_valid = &vld_s2;
	assign eq_hit    = |eq_s2;
	assign any_ge    = |ge_s2;

	always_comb begin
		pos      = '0;
		fill_enc = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (stop_oh[i]) begin
				pos = pos | SW'(i);
			end
			if (hole_oh[i]) begin
				fill_enc = fill_enc | FW'(i);
			end
		end
	end

	assign fill     = all_valid ? FW'(SLOTS) : fill_enc;
	assign fill_inc = fill + FW'(1);

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			if (!ge_s2[i]) begin
				row_wr[i] = row_rd[i];
			end else if (stop_oh[i] || i == 0) begin
				row_wr[i] = {1'b1, col};
			end else begin
				row_wr[i] = row_rd[(i > 0) ? i - 1 : 0];
			end
		end
	end

	always_comb begin
		if (eq_hit) begin
			res.insert = 1'b0;
			res.status = srsi_pkg::ST_PRESENT;
			res.slot   = srsi_pkg::SLOT_W'(pos);
			res.fill   = srsi_pkg::FILL_W'(fill);
		end else if (any_ge && !all_valid) begin
			res.insert = 1'b1;
			res.status = srsi_pkg::ST_INSERTED;
			res.slot   = srsi_pkg::SLOT_W'(pos);
			res.fill   = srsi_pkg::FILL_W'(fill_inc);
		end else begin
			res.insert = 1'b0;
			res.status = srsi_pkg::ST_FULL;
			res.slot   = '0;
			res.fill   = srsi_pkg::FILL_W'(fill);
		end
	end
endmodule
`default_nettype wire
